// ----- src/nge_pkg.sv -----
package nge_pkg;

	localparam int MAX_ITEMS  = 64;
	localparam int VALUE_BITS = 16;

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int POS_W = 6;
	localparam int ANS_W = VALUE_BITS + 1;

	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;

	localparam logic [PADDR_W-1:0] REG_DIRECTION = PADDR_W'(0);

	typedef enum logic {
		DIR_PREVIOUS = 1'b0,
		DIR_NEXT     = 1'b1
	} dir_t;

endpackage

// ----- src/nge_if.sv -----
interface nge_in_if;
	import nge_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;
	logic                  last_item;

	modport source (output valid, output value, output last_item, input ready);
	modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface nge_out_if;
	import nge_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [POS_W-1:0]      position;
	logic                  found;
	logic [VALUE_BITS-1:0] greater_value;
	logic                  overflow;
	logic                  last_result;

	modport source (
		output valid, output position, output found, output greater_value,
		output overflow, output last_result, input ready
	);
	modport sink (
		input valid, input position, input found, input greater_value,
		input overflow, input last_result, output ready
	);
endinterface

// ----- src/nge_ram.sv -----
module nge_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/nearest_greater_element.sv -----
// Previous mode: each accepted element runs S_POP, plus S_POPW per popped stack entry;
//   its result is registered when no pop is left and the output slot is free; next
//   transaction taken the cycle after. Next mode: elements are buffered; the last starts
//   a sweep down through S_SWP_RD, S_SWP_LD, S_POP (S_POPW per pop), then S_EMIT_RD and
//   S_EMIT emit results in order. Each pop reads the new top from the stack RAM.
// arst_n clears control, counts and direction; RAM contents are not cleared.
module nearest_greater_element (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nge_pkg::PADDR_W-1:0] paddr,
	input  logic [nge_pkg::PDATA_W-1:0] pwdata,
	output logic [nge_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	nge_in_if.sink                      items,
	nge_out_if.source                   results
);
	import nge_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_POPW,
		S_SWP_RD,
		S_SWP_LD,
		S_EMIT_RD,
		S_EMIT
	} state_t;

	state_t                state_q;
	dir_t                  direction_q;
	dir_t                  dir_q;
	logic [VALUE_BITS-1:0] v_q;
	logic [VALUE_BITS-1:0] top_q;
	logic                  last_q;
	logic [IDX_W-1:0]      idx_q;
	logic [CNT_W-1:0]      item_cnt_q;
	logic [CNT_W-1:0]      stk_cnt_q;
	logic                  overflow_q;

	logic                  out_valid_q;
	logic [POS_W-1:0]      out_pos_q;
	logic                  out_found_q;
	logic [VALUE_BITS-1:0] out_val_q;
	logic                  out_ovf_q;
	logic                  out_last_q;

	logic                  in_acc;
	logic                  item_ok;
	logic                  slot_free;
	logic                  pop;
	logic                  advance;
	logic                  out_load;
	logic                  found_c;
	logic [VALUE_BITS-1:0] gval_c;
	logic                  emit_last;
	logic                  cfg_wr;

	logic                  vbuf_we;
	logic                  vbuf_re;
	logic [VALUE_BITS-1:0] vbuf_rdata;
	logic                  stk_we;
	logic                  stk_re;
	logic [IDX_W-1:0]      stk_raddr;
	logic [VALUE_BITS-1:0] stk_rdata;
	logic                  abuf_we;
	logic                  abuf_re;
	logic [ANS_W-1:0]      abuf_rdata;

	assign pready = 1'b1;
	assign prdata = PDATA_W'(direction_q);
	assign cfg_wr = psel && penable && pwrite;

	assign items.ready = (state_q == S_IDLE);
	assign in_acc      = items.valid && items.ready;
	assign item_ok     = (item_cnt_q < CNT_W'(MAX_ITEMS));
	assign slot_free   = !out_valid_q || results.ready;

	assign pop       = (stk_cnt_q != '0) && (top_q <= v_q);
	assign found_c   = (stk_cnt_q != '0);
	assign gval_c    = found_c ? top_q : '0;
	assign advance   = (state_q == S_POP) && !pop && (dir_q == DIR_NEXT || slot_free);
	assign emit_last = (CNT_W'(idx_q) + CNT_W'(1)) == item_cnt_q;
	assign out_load  = (advance && dir_q == DIR_PREVIOUS) || (state_q == S_EMIT && slot_free);

	assign vbuf_we   = in_acc && item_ok;
	assign vbuf_re   = (state_q == S_SWP_RD);
	assign stk_re    = (state_q == S_POP) && pop;
	assign stk_raddr = IDX_W'(stk_cnt_q - CNT_W'(2));
	assign stk_we    = advance && (stk_cnt_q < CNT_W'(MAX_ITEMS));
	assign abuf_we   = advance && (dir_q == DIR_NEXT);
	assign abuf_re   = (state_q == S_EMIT_RD);

	nge_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_value_buf (
		.clk   (clk),
		.we    (vbuf_we),
		.waddr (item_cnt_q[IDX_W-1:0]),
		.wdata (items.value),
		.re    (vbuf_re),
		.raddr (idx_q),
		.rdata (vbuf_rdata)
	);

	nge_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_cnt_q[IDX_W-1:0]),
		.wdata (v_q),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	nge_ram #(.WIDTH(ANS_W), .DEPTH(MAX_ITEMS)) u_answer_buf (
		.clk   (clk),
		.we    (abuf_we),
		.waddr (idx_q),
		.wdata ({found_c, gval_c}),
		.re    (abuf_re),
		.raddr (idx_q),
		.rdata (abuf_rdata)
	);

	assign results.valid         = out_valid_q;
	assign results.position      = out_pos_q;
	assign results.found         = out_found_q;
	assign results.greater_value = out_val_q;
	assign results.overflow      = out_ovf_q;
	assign results.last_result   = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			direction_q <= DIR_PREVIOUS;
			dir_q       <= DIR_PREVIOUS;
			v_q         <= '0;
			top_q       <= '0;
			last_q      <= 1'b0;
			idx_q       <= '0;
			item_cnt_q  <= '0;
			stk_cnt_q   <= '0;
			overflow_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_pos_q   <= '0;
			out_found_q <= 1'b0;
			out_val_q   <= '0;
			out_ovf_q   <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_wr && paddr == REG_DIRECTION) begin
				direction_q <= dir_t'(pwdata[0]);
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
				out_pos_q   <= POS_W'(idx_q);
				out_ovf_q   <= overflow_q;
				if (state_q == S_EMIT) begin
					out_found_q <= abuf_rdata[ANS_W-1];
					out_val_q   <= abuf_rdata[VALUE_BITS-1:0];
					out_last_q  <= emit_last;
				end else begin
					out_found_q <= found_c;
					out_val_q   <= gval_c;
					out_last_q  <= last_q;
				end
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						v_q    <= items.value;
						last_q <= items.last_item;
						dir_q  <= direction_q;
						if (item_ok) begin
							item_cnt_q <= item_cnt_q + CNT_W'(1);
						end
						if (direction_q == DIR_PREVIOUS) begin
							idx_q <= item_cnt_q[IDX_W-1:0];
							if (item_ok) begin
								state_q <= S_POP;
							end else if (items.last_item) begin
								item_cnt_q <= '0;
								stk_cnt_q  <= '0;
								overflow_q <= 1'b0;
							end else begin
								overflow_q <= 1'b1;
							end
						end else begin
							if (!item_ok) begin
								overflow_q <= 1'b1;
							end
							idx_q <= item_ok ? item_cnt_q[IDX_W-1:0]
								: IDX_W'(item_cnt_q - CNT_W'(1));
							if (items.last_item) begin
								stk_cnt_q <= '0;
								state_q   <= S_SWP_RD;
							end
						end
					end
				end
				S_POP: begin
					if (pop) begin
						stk_cnt_q <= stk_cnt_q - CNT_W'(1);
						state_q   <= S_POPW;
					end else if (advance) begin
						if (dir_q == DIR_PREVIOUS && last_q) begin
							item_cnt_q <= '0;
							stk_cnt_q  <= '0;
							overflow_q <= 1'b0;
						end else if (stk_cnt_q < CNT_W'(MAX_ITEMS)) begin
							stk_cnt_q <= stk_cnt_q + CNT_W'(1);
							top_q     <= v_q;
						end
						if (dir_q == DIR_NEXT) begin
							if (idx_q == '0) begin
								state_q <= S_EMIT_RD;
							end else begin
								idx_q   <= idx_q - IDX_W'(1);
								state_q <= S_SWP_RD;
							end
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_POPW: begin
					top_q   <= stk_rdata;
					state_q <= S_POP;
				end
				S_SWP_RD: begin
					state_q <= S_SWP_LD;
				end
				S_SWP_LD: begin
					v_q     <= vbuf_rdata;
					state_q <= S_POP;
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						if (emit_last) begin
							item_cnt_q <= '0;
							stk_cnt_q  <= '0;
							overflow_q <= 1'b0;
							state_q    <= S_IDLE;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stk_cnt_q <= item_cnt_q)
		else $error("stack deeper than element count");

	a_item_bound: assert property (@(posedge clk) disable iff (!arst_n)
		item_cnt_q <= CNT_W'(MAX_ITEMS))
		else $error("element count beyond capacity");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && state_q == S_EMIT && emit_last) |=>
		(item_cnt_q == '0 && stk_cnt_q == '0 && !overflow_q))
		else $error("array state not cleared after final result");

	a_popw_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POPW) |-> ($past(state_q) == S_POP && $past(pop)))
		else $error("stack read without a pop");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (CNT_W'(idx_q) < item_cnt_q))
		else $error("emission index past stored elements");
`endif

endmodule

// ----- test/tb.sv -----
package nge_tb_pkg;
	import nge_pkg::*;

	typedef struct packed {
		logic [POS_W-1:0]      position;
		logic                  found;
		logic [VALUE_BITS-1:0] greater_value;
		logic                  overflow;
		logic                  last_result;
	} answer_t;

	class answer_board;
		logic [VALUE_BITS-1:0] stack_mem [MAX_ITEMS];
		int unsigned           stack_depth;
		logic [VALUE_BITS-1:0] held_values [MAX_ITEMS];
		int unsigned           held_count;
		bit                    dropped;
		dir_t                  dir;
		answer_t               pending_answers [$];
		int unsigned           mismatches;
		int unsigned           answers_checked;

		function new();
			stack_depth     = 0;
			held_count      = 0;
			dropped         = 0;
			dir             = DIR_PREVIOUS;
			mismatches      = 0;
			answers_checked = 0;
		endfunction

		function void set_direction(dir_t d);
			dir = d;
		endfunction

		function void pop_to_greater(input logic [VALUE_BITS-1:0] v, output logic hit,
				output logic [VALUE_BITS-1:0] top);
			while (stack_depth > 0 && stack_mem[stack_depth-1] <= v)
				stack_depth--;
			hit = stack_depth > 0;
			top = hit ? stack_mem[stack_depth-1] : '0;
		endfunction

		function void push_value(logic [VALUE_BITS-1:0] v);
			if (stack_depth < MAX_ITEMS) begin
				stack_mem[stack_depth] = v;
				stack_depth++;
			end
		endfunction

		function answer_t make_answer(int unsigned pos, logic hit, logic [VALUE_BITS-1:0] top,
				logic last);
			answer_t a;
			a.position      = POS_W'(pos);
			a.found         = hit;
			a.greater_value = hit ? top : '0;
			a.overflow      = dropped;
			a.last_result   = last;
			return a;
		endfunction

		function void predict_item(logic [VALUE_BITS-1:0] v, logic last);
			bit                    taken;
			logic                  hit;
			logic [VALUE_BITS-1:0] top;
			logic                  sweep_hit [MAX_ITEMS];
			logic [VALUE_BITS-1:0] sweep_top [MAX_ITEMS];
			int                    i;
			taken = held_count < MAX_ITEMS;
			if (taken)
				held_values[held_count] = v;
			else
				dropped = 1;
			if (dir == DIR_PREVIOUS) begin
				if (taken) begin
					pop_to_greater(v, hit, top);
					push_value(v);
					pending_answers.push_back(make_answer(held_count, hit, top, last));
					held_count++;
				end
			end else begin
				if (taken)
					held_count++;
				if (last) begin
					stack_depth = 0;
					for (i = held_count; i > 0; i--) begin
						pop_to_greater(held_values[i-1], sweep_hit[i-1], sweep_top[i-1]);
						push_value(held_values[i-1]);
					end
					for (i = 0; i < held_count; i++)
						pending_answers.push_back(make_answer(i, sweep_hit[i], sweep_top[i],
							i + 1 == held_count));
				end
			end
			if (last) begin
				held_count  = 0;
				stack_depth = 0;
				dropped     = 0;
			end
		endfunction

		function void check_answer(answer_t got);
			answer_t want;
			if (pending_answers.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected answer pos=%0d found=%0b value=%h overflow=%0b last=%0b",
					$time, got.position, got.found, got.greater_value, got.overflow,
					got.last_result);
				return;
			end
			want = pending_answers.pop_front();
			answers_checked++;
			if (got !== want) begin
				mismatches++;
				$display("%0t: answer mismatch", $time);
				$display("  expected pos=%0d found=%0b value=%h overflow=%0b last=%0b",
					want.position, want.found, want.greater_value, want.overflow,
					want.last_result);
				$display("  actual   pos=%0d found=%0b value=%h overflow=%0b last=%0b",
					got.position, got.found, got.greater_value, got.overflow,
					got.last_result);
			end
		endfunction
	endclass
endpackage

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import nge_pkg::*;
	import nge_tb_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_ITEMS  = 170;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	nge_in_if  items_if ();
	nge_out_if results_if ();

	nearest_greater_element i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.items   (items_if),
		.results (results_if)
	);

	answer_board board = new();
	int          burst_left = 0;
	int          items_sent = 0;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400_000;
		$display("CHECK FAILED");
		$finish;
	end

	// receiver: switches between always-ready, coin-flip and mostly-stalled
	initial begin
		int mode;
		int span;
		results_if.ready = 0;
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(32, 256);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: results_if.ready = 1;
					1: results_if.ready = $urandom_range(0, 1);
					default: results_if.ready = ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready)
			board.check_answer({results_if.position, results_if.found,
				results_if.greater_value, results_if.overflow, results_if.last_result});
	end

	function automatic logic [VALUE_BITS-1:0] pick_value();
		case ($urandom_range(0, 4))
			0: return VALUE_BITS'($urandom_range(0, 7));
			1: return {VALUE_BITS{1'b1}} - VALUE_BITS'($urandom_range(0, 7));
			2: return $urandom_range(0, 1) ? {VALUE_BITS{1'b1}} : '0;
			default: return VALUE_BITS'($urandom());
		endcase
	endfunction

	task automatic send_item(logic [VALUE_BITS-1:0] v, logic last);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 25) : $urandom_range(0, 3);
			if (gap > 0) begin
				items_if.valid = 0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) :
				$urandom_range(1, 8);
		end
		burst_left--;
		items_if.valid     = 1;
		items_if.value     = v;
		items_if.last_item = last;
		do @(posedge clk); while (!items_if.ready);
		board.predict_item(v, last);
		items_sent++;
	endtask

	task automatic send_run(logic [VALUE_BITS-1:0] vals [$], bit closes);
		foreach (vals[k])
			send_item(vals[k], closes && k == vals.size() - 1);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		items_if.valid = 0;
		burst_left = 0;
		while (board.pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_direction(dir_t d);
		@(negedge clk);
		psel    = 1;
		pwrite  = 1;
		penable = 0;
		paddr   = REG_DIRECTION;
		pwdata  = PDATA_W'(d);
		@(negedge clk);
		penable = 1;
		do @(posedge clk); while (!pready);
		board.set_direction(d);
		@(negedge clk);
		psel    = 0;
		penable = 0;
		pwrite  = 0;
	endtask

	initial begin
		logic [VALUE_BITS-1:0] run_vals [$];
		int   arrays_done;
		int   long_arrays;
		int   len;
		int   switch_at;
		int   k;
		dir_t d;

		arst_n             = 0;
		psel               = 0;
		penable            = 0;
		pwrite             = 0;
		paddr              = '0;
		pwdata             = '0;
		items_if.valid     = 0;
		items_if.value     = '0;
		items_if.last_item = 0;
		arrays_done        = 0;
		long_arrays        = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// previous mode from reset, then next mode: ties, extremes, single element
		run_vals = '{16'd5, 16'd3, 16'd3, 16'd7, 16'hFFFF, 16'd0, 16'hFFFF};
		send_run(run_vals, 1);
		run_vals = '{16'd0};
		send_run(run_vals, 1);
		wait_idle();
		write_direction(DIR_NEXT);
		run_vals = '{16'd2, 16'd9, 16'd9, 16'd1, 16'hFFFF, 16'd0, 16'd4};
		send_run(run_vals, 1);
		run_vals = '{16'hFFFF};
		send_run(run_vals, 1);

		// direction flipped inside an array
		run_vals = '{16'd3, 16'd8};
		send_run(run_vals, 0);
		wait_idle();
		write_direction(DIR_PREVIOUS);
		run_vals = '{16'd5, 16'd1};
		send_run(run_vals, 0);
		wait_idle();
		write_direction(DIR_NEXT);
		run_vals = '{16'd6};
		send_run(run_vals, 1);
		run_vals = '{16'd7};
		send_run(run_vals, 0);
		wait_idle();
		write_direction(DIR_PREVIOUS);
		run_vals = '{16'd1, 16'd9};
		send_run(run_vals, 1);
		arrays_done = 6;

		// random arrays; the first two run past capacity, one in each direction
		k = 0;
		while (items_sent < RANDOM_ITEMS) begin
			case (k)
				0: begin len = $urandom_range(65, 66); d = DIR_PREVIOUS; end
				1: begin len = $urandom_range(65, 66); d = DIR_NEXT; end
				default: begin
					len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 70) :
						$urandom_range(1, 10);
					d = dir_t'($urandom_range(0, 1));
				end
			endcase
			if (d != board.dir || $urandom_range(0, 3) == 0) begin
				wait_idle();
				write_direction(d);
			end
			switch_at = (len > 1 && $urandom_range(0, 6) == 0) ? $urandom_range(1, len - 1) : len;
			for (int j = 0; j < len; j++) begin
				if (j == switch_at) begin
					wait_idle();
					write_direction(board.dir == DIR_NEXT ? DIR_PREVIOUS : DIR_NEXT);
				end
				send_item(pick_value(), j == len - 1);
			end
			if (len > MAX_ITEMS)
				long_arrays++;
			arrays_done++;
			k++;
		end

		wait_idle();
		$display("Covered %0d arrays (%0d past capacity) in both directions, %0d items sent",
			arrays_done, long_arrays, items_sent);
		$display("%0d answers compared, %0d mismatches", board.answers_checked,
			board.mismatches);
		if (board.mismatches == 0 && board.pending_answers.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
